// ===== rtl/tlvsv_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the TLV record sequence validator.
// No dependencies; imported by the top level and its checker.
package tlvsv_pkg;

    localparam int BYTE_W     = 8;
    localparam int TDATA_IN_W = 8;
    localparam int TDATA_OUT_W = 8;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int HALF_W     = 16;
    localparam int WORD_W     = 32;
    localparam int POS_W      = 3;

    // Register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_VERSION = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_TAG          = 1'd1;

    // Reset values of the configuration registers
    localparam logic [HALF_W-1:0] EXPECTED_VERSION_RST = 16'd1;
    localparam logic [HALF_W-1:0] MAX_TAG_RST          = 16'd23;

    // Header byte positions
    localparam logic [POS_W-1:0] MSG_HDR_LAST_POS = 3'd3;
    localparam logic [POS_W-1:0] TAG_LAST_POS     = 3'd1;
    localparam logic [POS_W-1:0] REC_HDR_LAST_POS = 3'd5;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_TRUNCATED   = 3'd1,
        ST_INVALID     = 3'd2,
        ST_UNKNOWN_TAG = 3'd3,
        ST_TRAILING    = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        PH_HEADER = 4'b0001,
        PH_RECHDR = 4'b0010,
        PH_BODY   = 4'b0100,
        PH_DONE   = 4'b1000
    } phase_t;

endpackage

// ===== rtl/tlv_record_sequence_validator_top.sv =====
`timescale 1ns / 1ps
// TLV record sequence validator: one byte per request, one status per message.
// Depends on tlvsv_pkg.
//
// A final byte's status goes from the byte stage to the output register. Throughput:
// one byte per cycle unless a final byte waits; the parser step is one registered pass.
// The output register frees its slot on the same edge it hands a status over.
// Reset: rst_n clears all parser state, the byte stage and the output valid,
// and loads expected_version = 1 and max_tag = 23.
module tlv_record_sequence_validator_top (
    input  logic                                clk,
    input  logic                                rst_n,
    // byte input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [tlvsv_pkg::TDATA_IN_W-1:0]    s_axis_tdata,  // [7:0] byte_value
    input  logic                                s_axis_tlast,  // last_byte
    // status output stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [tlvsv_pkg::TDATA_OUT_W-1:0]   m_axis_tdata,  // [2:0] status, [7:3] zero
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tlvsv_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tlvsv_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import tlvsv_pkg::*;

    // Configuration registers
    logic [HALF_W-1:0] exp_version_reg;
    logic [HALF_W-1:0] max_tag_reg;

    // Byte stage
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;

    // Parser state
    phase_t            phase_reg,       phase_next;
    logic [POS_W-1:0]  byte_pos_reg,    byte_pos_next;
    logic [HALF_W-1:0] records_left_reg, records_left_next;
    logic [HALF_W-1:0] prev_tag_reg,    prev_tag_next;
    logic [WORD_W-1:0] field_shift_reg, field_shift_next;
    logic [WORD_W-1:0] body_left_reg,   body_left_next;
    status_t           error_reg,       error_next;

    // Output register
    logic              out_valid_reg;
    status_t           out_status_reg;

    logic              out_free;
    logic              proc_fire;
    status_t           status_calc;
    logic [HALF_W-1:0] tag;
    logic [HALF_W-1:0] rec_dec;
    logic [WORD_W-1:0] body_dec;

    // Configuration is always taken; the user changes it only while idle (unenforced).
    assign cfg_ready = 1'b1;

    // A byte that ends a message needs the output slot; other bytes never wait.
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign proc_fire     = in_valid_reg && (!in_last_reg || out_free);
    assign s_axis_tready = !in_valid_reg || proc_fire;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(TDATA_OUT_W-STATUS_W){1'b0}}, out_status_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_version_reg <= EXPECTED_VERSION_RST;
            max_tag_reg     <= MAX_TAG_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_EXPECTED_VERSION: exp_version_reg <= cfg_data;
                REG_MAX_TAG:          max_tag_reg     <= cfg_data;
                default:              ;
            endcase
        end
    end

    // Hold the byte stage while a final byte waits for the output slot.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            in_byte_reg  <= '0;
            in_last_reg  <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
            in_byte_reg  <= s_axis_tdata[BYTE_W-1:0];
            in_last_reg  <= s_axis_tlast;
        end
    end

    // One parser step for the byte held in the stage.
    always_comb
    begin
        field_shift_next  = {field_shift_reg[WORD_W-BYTE_W-1:0], in_byte_reg};
        phase_next        = phase_reg;
        byte_pos_next     = byte_pos_reg;
        records_left_next = records_left_reg;
        prev_tag_next     = prev_tag_reg;
        body_left_next    = body_left_reg;
        error_next        = error_reg;
        tag               = field_shift_next[HALF_W-1:0];
        rec_dec           = records_left_reg - 1'b1;
        body_dec          = body_left_reg - 1'b1;

        unique case (phase_reg)
            PH_HEADER:
            begin
                if (byte_pos_reg >= MSG_HDR_LAST_POS)
                begin
                    if (field_shift_next[WORD_W-1:HALF_W] != exp_version_reg)
                    begin
                        error_next = ST_INVALID;
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        records_left_next = field_shift_next[HALF_W-1:0];
                        byte_pos_next     = '0;
                        phase_next = (field_shift_next[HALF_W-1:0] == '0) ? PH_DONE
                                                                          : PH_RECHDR;
                    end
                end
                else
                begin
                    byte_pos_next = byte_pos_reg + 1'b1;
                end
            end
            PH_RECHDR:
            begin
                // Tag check lands on the second header byte; unknown wins over order.
                if (byte_pos_reg == TAG_LAST_POS)
                begin
                    if (tag == '0 || tag > max_tag_reg)
                        error_next = ST_UNKNOWN_TAG;
                    else if (tag <= prev_tag_reg)
                        error_next = ST_INVALID;
                    else
                        prev_tag_next = tag;
                end
                if (byte_pos_reg >= REC_HDR_LAST_POS)
                begin
                    if (error_reg != ST_OK)
                    begin
                        phase_next = PH_DONE;
                    end
                    else if (field_shift_next == '0)
                    begin
                        // Empty body: the record ends here.
                        records_left_next = rec_dec;
                        byte_pos_next     = '0;
                        phase_next = (rec_dec == '0) ? PH_DONE : PH_RECHDR;
                    end
                    else
                    begin
                        body_left_next = field_shift_next;
                        phase_next     = PH_BODY;
                    end
                end
                else
                begin
                    byte_pos_next = byte_pos_reg + 1'b1;
                end
            end
            PH_BODY:
            begin
                body_left_next = body_dec;
                if (body_dec == '0)
                begin
                    records_left_next = rec_dec;
                    byte_pos_next     = '0;
                    phase_next = (rec_dec == '0) ? PH_DONE : PH_RECHDR;
                end
            end
            PH_DONE:
            begin
                if (error_reg == ST_OK)
                    error_next = ST_TRAILING;
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase

        // Ending before the parser reaches its done phase is a truncation.
        status_calc = (phase_next == PH_DONE) ? error_next : ST_TRUNCATED;
    end

    // Advance parser state; drop back to the message header after a final byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HEADER;
            byte_pos_reg     <= '0;
            records_left_reg <= '0;
            prev_tag_reg     <= '0;
            field_shift_reg  <= '0;
            body_left_reg    <= '0;
            error_reg        <= ST_OK;
        end
        else if (proc_fire)
        begin
            if (in_last_reg)
            begin
                phase_reg        <= PH_HEADER;
                byte_pos_reg     <= '0;
                records_left_reg <= '0;
                prev_tag_reg     <= '0;
                field_shift_reg  <= '0;
                body_left_reg    <= '0;
                error_reg        <= ST_OK;
            end
            else
            begin
                phase_reg        <= phase_next;
                byte_pos_reg     <= byte_pos_next;
                records_left_reg <= records_left_next;
                prev_tag_reg     <= prev_tag_next;
                field_shift_reg  <= field_shift_next;
                body_left_reg    <= body_left_next;
                error_reg        <= error_next;
            end
        end
    end

    // Output register: load on a final byte, clear once the status is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_OK;
        end
        else if (proc_fire && in_last_reg)
        begin
            out_valid_reg  <= 1'b1;
            out_status_reg <= status_calc;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

endmodule

// ===== rtl/tlvsv_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the TLV record sequence validator, bound to the top level.
// Depends on tlvsv_pkg.
module tlvsv_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic                                s_axis_tlast,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [tlvsv_pkg::TDATA_OUT_W-1:0]   m_axis_tdata,
    input logic                                cfg_valid,
    input logic                                cfg_ready
);
    import tlvsv_pkg::*;

    // Status codes stay in the defined range.
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[STATUS_W-1:0] == ST_OK
                        || m_axis_tdata[STATUS_W-1:0] == ST_TRUNCATED
                        || m_axis_tdata[STATUS_W-1:0] == ST_INVALID
                        || m_axis_tdata[STATUS_W-1:0] == ST_UNKNOWN_TAG
                        || m_axis_tdata[STATUS_W-1:0] == ST_TRAILING))
        else $error("status out of range");

    // Padding above the status is zero.
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[TDATA_OUT_W-1:STATUS_W] == '0))
        else $error("status padding not zero");

    // A stalled status holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled status changed");

    // A status that appears on an empty output comes from a final byte taken earlier.
    a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast, 2))
        else $error("unexpected status");

    // Configuration writes are never stalled.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind tlv_record_sequence_validator_top tlvsv_checker u_tlvsv_checker (.*);
